@@ design/ssh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssh_pkg: shared types and constants for the speech segment hysteresis block
// Register map, command codes, reset values and the item/result records.
// ----------------------------------------------------------------------------
`default_nettype none

package ssh_pkg;

  localparam int POSITION_BITS_DEF = 31;
  localparam int TIME_BITS         = 31;
  localparam int PROB_BITS         = 16;
  localparam int LEN_BITS          = 24;
  localparam int WLEN_BITS         = 16;
  localparam int CFG_DATA_BITS     = 24;
  localparam int CFG_INDEX_BITS    = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ON_THRESHOLD  = 3'd0,
    REG_OFF_THRESHOLD = 3'd1,
    REG_MIN_SILENCE   = 3'd2,
    REG_MIN_SPEECH    = 3'd3,
    REG_WINDOW_LENGTH = 3'd4
  } reg_idx_t;

  localparam logic CMD_WINDOW = 1'b0;
  localparam logic CMD_END    = 1'b1;

  localparam logic [PROB_BITS-1:0] ON_THRESHOLD_RST  = 16'd32768;
  localparam logic [PROB_BITS-1:0] OFF_THRESHOLD_RST = 16'd22938;
  localparam logic [LEN_BITS-1:0]  MIN_SILENCE_RST   = 24'd1600;
  localparam logic [LEN_BITS-1:0]  MIN_SPEECH_RST    = 24'd4000;
  localparam logic [WLEN_BITS-1:0] WINDOW_LENGTH_RST = 16'd512;

  typedef struct packed {
    logic [PROB_BITS-1:0] on_threshold;
    logic [PROB_BITS-1:0] off_threshold;
    logic [LEN_BITS-1:0]  min_silence;
    logic [LEN_BITS-1:0]  min_speech;
    logic [WLEN_BITS-1:0] window_length;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic [PROB_BITS-1:0] window_prob;
    logic [TIME_BITS-1:0] stream_samples;
  } item_t;

  typedef struct packed {
    logic                 hit;
    logic [TIME_BITS-1:0] segment_start;
    logic [TIME_BITS-1:0] segment_end;
  } seg_t;

endpackage

`default_nettype wire

@@ design/ssh_step.sv @@
// ----------------------------------------------------------------------------
// ssh_step: per-item segmenter update
// Combinational next-state and result for one window or end request.
// ----------------------------------------------------------------------------
`default_nettype none

module ssh_step
  import ssh_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire cfg_t                     cfg,
  input  wire item_t                    item,
  input  wire logic                     speaking,
  input  wire logic [POSITION_BITS-1:0] speech_begin,
  input  wire logic [POSITION_BITS-1:0] silence_begin,
  input  wire logic [POSITION_BITS-1:0] window_position,
  output logic                          speaking_next,
  output logic [POSITION_BITS-1:0]      speech_begin_next,
  output logic [POSITION_BITS-1:0]      silence_begin_next,
  output logic [POSITION_BITS-1:0]      window_position_next,
  output seg_t                          result
);

  // common compare width, wide enough for positions, lengths and stream counts
  localparam int CW = (POSITION_BITS > TIME_BITS) ? POSITION_BITS : TIME_BITS;

  logic [CW-1:0]            p_w;
  logic [CW-1:0]            sb_w;
  logic [CW-1:0]            sil_w;
  logic [CW-1:0]            total_w;
  logic [CW-1:0]            min_sil_w;
  logic [CW-1:0]            min_sp_w;
  logic [POSITION_BITS-1:0] sil_eff;
  logic [POSITION_BITS:0]   pos_sum;
  logic                     close_seg;
  logic                     long_seg;
  logic                     end_report;

  always_comb begin
    sil_eff   = (silence_begin == '0) ? window_position : silence_begin;
    p_w       = CW'(window_position);
    sb_w      = CW'(speech_begin);
    sil_w     = CW'(sil_eff);
    total_w   = CW'(item.stream_samples);
    min_sil_w = CW'(cfg.min_silence);
    min_sp_w  = CW'(cfg.min_speech);

    close_seg  = (p_w >= sil_w) && ((p_w - sil_w) >= min_sil_w);
    long_seg   = (sil_w >= sb_w) && ((sil_w - sb_w) >= min_sp_w);
    end_report = speaking && (total_w >= sb_w) && ((total_w - sb_w) >= min_sp_w);

    // saturating position advance
    pos_sum = {1'b0, window_position} + (POSITION_BITS+1)'(cfg.window_length);
  end

  always_comb begin
    speaking_next        = speaking;
    speech_begin_next    = speech_begin;
    silence_begin_next   = silence_begin;
    window_position_next = pos_sum[POSITION_BITS] ? '1 : pos_sum[POSITION_BITS-1:0];
    result.hit           = 1'b0;
    result.segment_start = sb_w[TIME_BITS-1:0];
    result.segment_end   = sil_w[TIME_BITS-1:0];

    if (item.cmd == CMD_END) begin
      result.hit           = end_report;
      result.segment_end   = item.stream_samples;
      speaking_next        = 1'b0;
      speech_begin_next    = '0;
      silence_begin_next   = '0;
      window_position_next = '0;
    end else if (item.window_prob >= cfg.on_threshold) begin
      silence_begin_next = '0;
      if (!speaking) begin
        speaking_next     = 1'b1;
        speech_begin_next = window_position;
      end
    end else if (speaking && (item.window_prob < cfg.off_threshold)) begin
      silence_begin_next = sil_eff;
      if (close_seg) begin
        result.hit         = long_seg;
        speaking_next      = 1'b0;
        silence_begin_next = '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/speech_segment_hysteresis.sv @@
// ----------------------------------------------------------------------------
// speech_segment_hysteresis: voice activity segmenter with hangover
// Turns per-window speech probabilities into (start, end) sample segments.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | cmd, window_prob, stream_samples
//   out      | out_valid/out_stall| segment_start, segment_end
//   cfg      | cfg_write          | cfg_index, cfg_data
//
// One request per cycle while the result is not stalled. A request is held in
// the input register, is processed against the segment state, and a hit lands
// in the output register. Only a stalled result holds the pipe.
// Synchronous reset clears the state and loads default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module speech_segment_hysteresis
  import ssh_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      cmd,
  input  wire logic [PROB_BITS-1:0]      window_prob,
  input  wire logic [TIME_BITS-1:0]      stream_samples,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [TIME_BITS-1:0]           segment_start,
  output logic [TIME_BITS-1:0]           segment_end
);

  cfg_t                     cfg;
  item_t                    item;
  logic                     item_valid;
  logic                     speaking;
  logic [POSITION_BITS-1:0] speech_begin;
  logic [POSITION_BITS-1:0] silence_begin;
  logic [POSITION_BITS-1:0] window_position;
  logic                     speaking_next;
  logic [POSITION_BITS-1:0] speech_begin_next;
  logic [POSITION_BITS-1:0] silence_begin_next;
  logic [POSITION_BITS-1:0] window_position_next;
  seg_t                     result;
  logic                     advance;

  // the processing stage moves whenever the result register is free
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_threshold  <= ON_THRESHOLD_RST;
      cfg.off_threshold <= OFF_THRESHOLD_RST;
      cfg.min_silence   <= MIN_SILENCE_RST;
      cfg.min_speech    <= MIN_SPEECH_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ON_THRESHOLD:  cfg.on_threshold  <= cfg_data[PROB_BITS-1:0];
        REG_OFF_THRESHOLD: cfg.off_threshold <= cfg_data[PROB_BITS-1:0];
        REG_MIN_SILENCE:   cfg.min_silence   <= cfg_data[LEN_BITS-1:0];
        REG_MIN_SPEECH:    cfg.min_speech    <= cfg_data[LEN_BITS-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[WLEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.cmd            <= cmd;
      item.window_prob    <= window_prob;
      item.stream_samples <= stream_samples;
    end
  end

  ssh_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .cfg                 (cfg),
    .item                (item),
    .speaking            (speaking),
    .speech_begin        (speech_begin),
    .silence_begin       (silence_begin),
    .window_position     (window_position),
    .speaking_next       (speaking_next),
    .speech_begin_next   (speech_begin_next),
    .silence_begin_next  (silence_begin_next),
    .window_position_next(window_position_next),
    .result              (result)
  );

  // segment state
  always_ff @(posedge clk) begin
    if (rst) begin
      speaking        <= 1'b0;
      speech_begin    <= '0;
      silence_begin   <= '0;
      window_position <= '0;
    end else if (item_valid && advance) begin
      speaking        <= speaking_next;
      speech_begin    <= speech_begin_next;
      silence_begin   <= silence_begin_next;
      window_position <= window_position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid && result.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid && result.hit) begin
      segment_start <= result.segment_start;
      segment_end   <= result.segment_end;
    end
  end

endmodule

`default_nettype wire
